@@ sv/ajs_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, code constants and presentation-form tables for the Arabic joining-form shaper.
package ajs_pkg;

	localparam int CODE_W   = 21;
	localparam int GLYPH_W  = 16;
	localparam int QDEPTH   = 2;
	localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W   = $clog2(QDEPTH + 1);

	// Character set codes
	localparam logic [1:0] SET_NONE  = 2'd0;
	localparam logic [1:0] SET_UNI2  = 2'd1;
	localparam logic [1:0] SET_UNI4  = 2'd2;

	localparam logic [GLYPH_W-1:0] LAM = 16'h0644;

	typedef struct packed {
		logic [GLYPH_W-1:0] iso;
		logic [GLYPH_W-1:0] rgt;
		logic [GLYPH_W-1:0] lft;
		logic [GLYPH_W-1:0] both;
		logic               hit;
	} form_t;

	typedef struct packed {
		logic [GLYPH_W-1:0] iso;
		logic [GLYPH_W-1:0] rgt;
		logic               hit;
	} lig_t;

	// One classified character as it travels from front to back
	typedef struct packed {
		logic [CODE_W-1:0]  code;
		logic               line_end;
		logic               form_hit;
		logic               right_ok;
		logic               left_ok;
		logic [GLYPH_W-1:0] iso;
		logic [GLYPH_W-1:0] rgt;
		logic [GLYPH_W-1:0] lft;
		logic [GLYPH_W-1:0] both;
		logic               lig_hit;
		logic [GLYPH_W-1:0] lig_iso;
		logic [GLYPH_W-1:0] lig_rgt;
	} cls_t;

	// Presentation forms: isolated, right-joined, left-joined, both-joined
	function automatic form_t form_lookup(input logic [GLYPH_W-1:0] c);
		form_t f;
		unique case (c)
			16'h0621: f = '{16'hFE80, 16'h0000, 16'h0000, 16'h0000, 1'b1};
			16'h0622: f = '{16'hFE81, 16'hFE82, 16'h0000, 16'h0000, 1'b1};
			16'h0623: f = '{16'hFE83, 16'hFE84, 16'h0000, 16'h0000, 1'b1};
			16'h0624: f = '{16'hFE85, 16'hFE86, 16'h0000, 16'h0000, 1'b1};
			16'h0625: f = '{16'hFE87, 16'hFE88, 16'h0000, 16'h0000, 1'b1};
			16'h0626: f = '{16'hFE89, 16'hFE8A, 16'hFE8B, 16'hFE8C, 1'b1};
			16'h0627: f = '{16'hFE8D, 16'hFE8E, 16'h0000, 16'h0000, 1'b1};
			16'h0628: f = '{16'hFE8F, 16'hFE90, 16'hFE91, 16'hFE92, 1'b1};
			16'h0629: f = '{16'hFE93, 16'hFE94, 16'h0000, 16'h0000, 1'b1};
			16'h062A: f = '{16'hFE95, 16'hFE96, 16'hFE97, 16'hFE98, 1'b1};
			16'h062B: f = '{16'hFE99, 16'hFE9A, 16'hFE9B, 16'hFE9C, 1'b1};
			16'h062C: f = '{16'hFE9D, 16'hFE9E, 16'hFE9F, 16'hFEA0, 1'b1};
			16'h062D: f = '{16'hFEA1, 16'hFEA2, 16'hFEA3, 16'hFEA4, 1'b1};
			16'h062E: f = '{16'hFEA5, 16'hFEA6, 16'hFEA7, 16'hFEA8, 1'b1};
			16'h062F: f = '{16'hFEA9, 16'hFEAA, 16'h0000, 16'h0000, 1'b1};
			16'h0630: f = '{16'hFEAB, 16'hFEAC, 16'h0000, 16'h0000, 1'b1};
			16'h0631: f = '{16'hFEAD, 16'hFEAE, 16'h0000, 16'h0000, 1'b1};
			16'h0632: f = '{16'hFEAF, 16'hFEB0, 16'h0000, 16'h0000, 1'b1};
			16'h0633: f = '{16'hFEB1, 16'hFEB2, 16'hFEB3, 16'hFEB4, 1'b1};
			16'h0634: f = '{16'hFEB5, 16'hFEB6, 16'hFEB7, 16'hFEB8, 1'b1};
			16'h0635: f = '{16'hFEB9, 16'hFEBA, 16'hFEBB, 16'hFEBC, 1'b1};
			16'h0636: f = '{16'hFEBD, 16'hFEBE, 16'hFEBF, 16'hFEC0, 1'b1};
			16'h0637: f = '{16'hFEC1, 16'hFEC2, 16'hFEC3, 16'hFEC4, 1'b1};
			16'h0638: f = '{16'hFEC5, 16'hFEC6, 16'hFEC7, 16'hFEC8, 1'b1};
			16'h0639: f = '{16'hFEC9, 16'hFECA, 16'hFECB, 16'hFECC, 1'b1};
			16'h063A: f = '{16'hFECD, 16'hFECE, 16'hFECF, 16'hFED0, 1'b1};
			16'h0640: f = '{16'h0640, 16'h0640, 16'h0640, 16'h0640, 1'b1};
			16'h0641: f = '{16'hFED1, 16'hFED2, 16'hFED3, 16'hFED4, 1'b1};
			16'h0642: f = '{16'hFED5, 16'hFED6, 16'hFED7, 16'hFED8, 1'b1};
			16'h0643: f = '{16'hFED9, 16'hFEDA, 16'hFEDB, 16'hFEDC, 1'b1};
			16'h0644: f = '{16'hFEDD, 16'hFEDE, 16'hFEDF, 16'hFEE0, 1'b1};
			16'h0645: f = '{16'hFEE1, 16'hFEE2, 16'hFEE3, 16'hFEE4, 1'b1};
			16'h0646: f = '{16'hFEE5, 16'hFEE6, 16'hFEE7, 16'hFEE8, 1'b1};
			16'h0647: f = '{16'hFEE9, 16'hFEEA, 16'hFEEB, 16'hFEEC, 1'b1};
			16'h0648: f = '{16'hFEED, 16'hFEEE, 16'h0000, 16'h0000, 1'b1};
			16'h0649: f = '{16'hFEEF, 16'hFEF0, 16'hFBE8, 16'hFBE9, 1'b1};
			16'h064A: f = '{16'hFEF1, 16'hFEF2, 16'hFEF3, 16'hFEF4, 1'b1};
			16'h0671: f = '{16'hFB50, 16'hFB51, 16'h0000, 16'h0000, 1'b1};
			16'h0679: f = '{16'hFB66, 16'hFB67, 16'hFB68, 16'hFB69, 1'b1};
			16'h067A: f = '{16'hFB5E, 16'hFB5F, 16'hFB60, 16'hFB61, 1'b1};
			16'h067B: f = '{16'hFB52, 16'hFB53, 16'hFB54, 16'hFB55, 1'b1};
			16'h067E: f = '{16'hFB56, 16'hFB57, 16'hFB58, 16'hFB59, 1'b1};
			16'h067F: f = '{16'hFB62, 16'hFB63, 16'hFB64, 16'hFB65, 1'b1};
			16'h0680: f = '{16'hFB5A, 16'hFB5B, 16'hFB5C, 16'hFB5D, 1'b1};
			16'h0683: f = '{16'hFB76, 16'hFB77, 16'hFB78, 16'hFB79, 1'b1};
			16'h0684: f = '{16'hFB72, 16'hFB73, 16'hFB74, 16'hFB75, 1'b1};
			16'h0686: f = '{16'hFB7A, 16'hFB7B, 16'hFB7C, 16'hFB7D, 1'b1};
			16'h0687: f = '{16'hFB7E, 16'hFB7F, 16'hFB80, 16'hFB81, 1'b1};
			16'h0688: f = '{16'hFB88, 16'hFB89, 16'h0000, 16'h0000, 1'b1};
			16'h068C: f = '{16'hFB84, 16'hFB85, 16'h0000, 16'h0000, 1'b1};
			16'h068D: f = '{16'hFB82, 16'hFB83, 16'h0000, 16'h0000, 1'b1};
			16'h068E: f = '{16'hFB86, 16'hFB87, 16'h0000, 16'h0000, 1'b1};
			16'h0691: f = '{16'hFB8C, 16'hFB8D, 16'h0000, 16'h0000, 1'b1};
			16'h0698: f = '{16'hFB8A, 16'hFB8B, 16'h0000, 16'h0000, 1'b1};
			16'h06A4: f = '{16'hFB6A, 16'hFB6B, 16'hFB6C, 16'hFB6D, 1'b1};
			16'h06A6: f = '{16'hFB6E, 16'hFB6F, 16'hFB70, 16'hFB71, 1'b1};
			16'h06A9: f = '{16'hFB8E, 16'hFB8F, 16'hFB90, 16'hFB91, 1'b1};
			16'h06AD: f = '{16'hFBD3, 16'hFBD4, 16'hFBD5, 16'hFBD6, 1'b1};
			16'h06AF: f = '{16'hFB92, 16'hFB93, 16'hFB94, 16'hFB95, 1'b1};
			16'h06B1: f = '{16'hFB9A, 16'hFB9B, 16'hFB9C, 16'hFB9D, 1'b1};
			16'h06B3: f = '{16'hFB96, 16'hFB97, 16'hFB98, 16'hFB99, 1'b1};
			16'h06BB: f = '{16'hFBA0, 16'hFBA1, 16'hFBA2, 16'hFBA3, 1'b1};
			16'h06BE: f = '{16'hFBAA, 16'hFBAB, 16'hFBAC, 16'hFBAD, 1'b1};
			16'h06C0: f = '{16'hFBA4, 16'hFBA5, 16'h0000, 16'h0000, 1'b1};
			16'h06C1: f = '{16'hFBA6, 16'hFBA7, 16'hFBA8, 16'hFBA9, 1'b1};
			16'h06C5: f = '{16'hFBE0, 16'hFBE1, 16'h0000, 16'h0000, 1'b1};
			16'h06C6: f = '{16'hFBD9, 16'hFBDA, 16'h0000, 16'h0000, 1'b1};
			16'h06C7: f = '{16'hFBD7, 16'hFBD8, 16'h0000, 16'h0000, 1'b1};
			16'h06C8: f = '{16'hFBDB, 16'hFBDC, 16'h0000, 16'h0000, 1'b1};
			16'h06C9: f = '{16'hFBE2, 16'hFBE3, 16'h0000, 16'h0000, 1'b1};
			16'h06CB: f = '{16'hFBDE, 16'hFBDF, 16'h0000, 16'h0000, 1'b1};
			16'h06CC: f = '{16'hFBFC, 16'hFBFD, 16'hFBFE, 16'hFBFF, 1'b1};
			16'h06D0: f = '{16'hFBE4, 16'hFBE5, 16'hFBE6, 16'hFBE7, 1'b1};
			16'h06D2: f = '{16'hFBAE, 16'hFBAF, 16'h0000, 16'h0000, 1'b1};
			16'h06D3: f = '{16'hFBB0, 16'hFBB1, 16'h0000, 16'h0000, 1'b1};
			default:  f = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0};
		endcase
		return f;
	endfunction

	// Lam-alef ligatures keyed by the attached alef
	function automatic lig_t lig_lookup(input logic [GLYPH_W-1:0] c);
		lig_t l;
		unique case (c)
			16'h0622: l = '{16'hFEF5, 16'hFEF6, 1'b1};
			16'h0623: l = '{16'hFEF7, 16'hFEF8, 1'b1};
			16'h0625: l = '{16'hFEF9, 16'hFEFA, 1'b1};
			16'h0627: l = '{16'hFEFB, 16'hFEFC, 1'b1};
			default:  l = '{16'h0000, 16'h0000, 1'b0};
		endcase
		return l;
	endfunction

endpackage

@@ sv/ajs_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input characters and shaped glyphs.
interface ajs_char_if;
	logic                        valid;
	logic                        ready;
	logic [ajs_pkg::CODE_W-1:0]  char_code;
	logic [1:0]                  char_set;
	logic                        comb_present;
	logic [ajs_pkg::GLYPH_W-1:0] comb_code;
	logic                        line_end;

	modport source(output valid, char_code, char_set, comb_present, comb_code, line_end,
		input ready);
	modport sink(input valid, char_code, char_set, comb_present, comb_code, line_end,
		output ready);
endinterface

interface ajs_glyph_if;
	logic                       valid;
	logic                       ready;
	logic [ajs_pkg::CODE_W-1:0] shaped_code;
	logic                       line_last;

	modport source(output valid, shaped_code, line_last, input ready);
	modport sink(input valid, shaped_code, line_last, output ready);
endinterface

@@ sv/ajs_front.sv @@
`timescale 1ns / 1ps
// Front end: accept characters, classify them against the form and ligature tables.
module ajs_front (
	input  logic              clk,
	input  logic              arst_n,
	ajs_char_if.sink          chars,
	output logic              push_valid,
	input  logic              push_ready,
	output ajs_pkg::cls_t     push_data
);
	logic          v_s1;
	ajs_pkg::cls_t cls_s1;
	ajs_pkg::cls_t cls_d;
	ajs_pkg::form_t f;
	ajs_pkg::lig_t  l;
	logic           uni;

	assign chars.ready = !v_s1 || push_ready;
	assign push_valid  = v_s1;
	assign push_data   = cls_s1;

	always_comb begin
		uni = (chars.char_set == ajs_pkg::SET_UNI2) || (chars.char_set == ajs_pkg::SET_UNI4);
		f   = ajs_pkg::form_lookup(chars.char_code[ajs_pkg::GLYPH_W-1:0]);
		l   = ajs_pkg::lig_lookup(chars.comb_code);
		cls_d.code     = chars.char_code;
		cls_d.line_end = chars.line_end;
		cls_d.form_hit = uni && f.hit;
		cls_d.right_ok = uni && f.hit && (f.rgt != '0);
		cls_d.left_ok  = uni && f.hit && (f.lft != '0);
		cls_d.iso      = f.iso;
		cls_d.rgt      = f.rgt;
		cls_d.lft      = f.lft;
		cls_d.both     = f.both;
		cls_d.lig_hit  = uni && chars.comb_present && l.hit
			&& (chars.char_code[ajs_pkg::GLYPH_W-1:0] == ajs_pkg::LAM);
		cls_d.lig_iso  = l.iso;
		cls_d.lig_rgt  = l.rgt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (chars.ready) begin
			v_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			cls_s1 <= cls_d;
		end
	end
endmodule

@@ sv/ajs_queue.sv @@
`timescale 1ns / 1ps
// Short queue of classified words between front and back.
module ajs_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  ajs_pkg::cls_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output ajs_pkg::cls_t pop_data
);
	ajs_pkg::cls_t                   mem_q [ajs_pkg::QDEPTH];
	logic [ajs_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [ajs_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [ajs_pkg::QCNT_W-1:0]      count_q;
	logic                            push_fire;
	logic                            pop_fire;

	assign push_ready = (count_q != ajs_pkg::QCNT_W'(ajs_pkg::QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;

	function automatic logic [ajs_pkg::QPTR_W-1:0] ptr_next(
		input logic [ajs_pkg::QPTR_W-1:0] p);
		return (p == ajs_pkg::QPTR_W'(ajs_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_fire) wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop_fire)  rd_ptr_q <= ptr_next(rd_ptr_q);
			if (push_fire && !pop_fire)      count_q <= count_q + 1'b1;
			else if (pop_fire && !push_fire) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push_fire) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end
endmodule

@@ sv/ajs_back.sv @@
`timescale 1ns / 1ps
// Back end: hold one word for lookahead, pick its joining form and drive the output register.
module ajs_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pop_valid,
	output logic          pop_ready,
	input  ajs_pkg::cls_t pop_data,
	ajs_glyph_if.source   glyphs
);
	ajs_pkg::cls_t              held_q;
	logic                       held_v_q;
	logic                       prev_right_q;
	logic                       out_v_q;
	logic [ajs_pkg::CODE_W-1:0] out_code_q;
	logic                       out_last_q;

	logic                       can_emit;
	logic                       emit;
	logic                       pop_fire;
	logic                       nl_raw;
	logic                       nl;
	logic [ajs_pkg::CODE_W-1:0] shaped;

	assign glyphs.valid       = out_v_q;
	assign glyphs.shaped_code = out_code_q;
	assign glyphs.line_last   = out_last_q;

	assign can_emit  = !out_v_q || glyphs.ready;
	// A held last word drains on its own; otherwise the next word must arrive with it
	assign pop_ready = !held_v_q || (!held_q.line_end && can_emit);
	assign pop_fire  = pop_valid && pop_ready;
	assign emit      = held_v_q && can_emit && (held_q.line_end || pop_valid);

	always_comb begin
		nl_raw = !held_q.line_end && pop_data.left_ok;
		nl     = nl_raw && !pop_data.lig_hit;
		if (held_q.lig_hit) begin
			shaped = {5'b0, nl_raw ? held_q.lig_rgt : held_q.lig_iso};
		end else if (!held_q.form_hit) begin
			shaped = held_q.code;
		end else if (prev_right_q && nl) begin
			priority if (held_q.both != '0) shaped = {5'b0, held_q.both};
			else if (held_q.left_ok)        shaped = {5'b0, held_q.lft};
			else if (held_q.right_ok)       shaped = {5'b0, held_q.rgt};
			else                            shaped = {5'b0, held_q.iso};
		end else if (prev_right_q) begin
			shaped = {5'b0, held_q.left_ok ? held_q.lft : held_q.iso};
		end else if (nl) begin
			shaped = {5'b0, held_q.right_ok ? held_q.rgt : held_q.iso};
		end else begin
			shaped = {5'b0, held_q.iso};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_v_q     <= 1'b0;
			prev_right_q <= 1'b0;
			out_v_q      <= 1'b0;
		end else begin
			if (pop_fire)  held_v_q <= 1'b1;
			else if (emit) held_v_q <= 1'b0;
			if (emit) prev_right_q <= !held_q.line_end && held_q.right_ok;
			if (emit)              out_v_q <= 1'b1;
			else if (glyphs.ready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_fire) held_q <= pop_data;
		if (emit) begin
			out_code_q <= shaped;
			out_last_q <= held_q.line_end;
		end
	end

`ifndef SYNTH
	a_emit_needs_held: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> held_v_q)
		else $error("word emitted with nothing held");
	a_last_clears_join: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && held_q.line_end) |=> (!prev_right_q && out_v_q && out_last_q))
		else $error("line end did not reset joining context");
	a_no_pop_past_last: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop_fire && held_v_q && held_q.line_end))
		else $error("next word taken while a line end is pending");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !glyphs.ready) |=> (out_v_q && $stable(out_code_q)))
		else $error("output register overwritten under back-pressure");
`endif
endmodule

@@ sv/arabic_joining_form_shaper.sv @@
`timescale 1ns / 1ps
// Top level of the Arabic joining-form shaper: front classifier, queue and shaping back end.
// A word's glyph enters the output register when its successor has passed the front register
// and queue; the last word of a line passes front register, queue, held and output registers.
// Throughput: one word a cycle while glyphs.ready holds; the held last character of a line
// drains with no lookahead, and the back end takes no new word until it has drained.
// Reset: arst_n clears every valid flag and the joining context at once; tables are constant.
module arabic_joining_form_shaper (
	input  logic        clk,
	input  logic        arst_n,
	ajs_char_if.sink    chars,
	ajs_glyph_if.source glyphs
);
	// Front to queue
	logic          f_valid;
	logic          f_ready;
	ajs_pkg::cls_t f_data;
	// Queue to back
	logic          b_valid;
	logic          b_ready;
	ajs_pkg::cls_t b_data;

	// Classify each character against the presentation and ligature tables
	ajs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.chars      (chars),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_data)
	);

	// Decouple the two halves so either may stall alone
	ajs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_data),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (b_data)
	);

	// Hold one word for lookahead, choose its form, register the glyph
	ajs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (b_valid),
		.pop_ready (b_ready),
		.pop_data  (b_data),
		.glyphs    (glyphs)
	);
endmodule
